@@ sv/stbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and types for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // default number of table entries
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // width of one table entry and of a search key
    localparam int VALUE_W = 32;

    // operation carried by an input word
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

endpackage
`default_nettype wire

@@ sv/stbs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and a read enable that holds the output.
// ----------------------------------------------------------------------------
module stbs_ram
    import stbs_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an entry register, then a read stage and a compare stage per probe level,
//   LEVELS = clog2(TABLE_DEPTH+1); one probe level is a RAM read plus a compare.
// Throughput: one word per cycle while the output is not stalled, searches and table writes
//   alike; each level owns a full copy of the table so every level probes its own RAM port.
// Reset: clears stage valid bits and the entry count; table contents stay undefined.
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Pipelined binary search over a software-loaded sorted table. Table writes
// travel the pipeline and update each level's copy as they pass it, so order
// between writes and searches is kept.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CW-1:0]             i_cfg_data,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_op,
    input  wire logic [IW-1:0]             i_entry_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_found,
    output logic [IW-1:0]                  o_match_index
);

    localparam int LEVELS = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_C = (CW+1)'(TABLE_DEPTH);

    // one word moving down the pipeline; span is [lo, hi_end)
    typedef struct packed {
        t_op                      op;
        logic [IW-1:0]            idx;
        logic signed [VALUE_W-1:0] value;
        logic [CW-1:0]            lo;
        logic [CW-1:0]            hi_end;
        logic [IW-1:0]            mid;
        logic                     found;
        logic [IW-1:0]            match;
    } t_item;

    logic  [CW-1:0] r_count;
    logic  [CW-1:0] n_count;
    logic           w_adv;
    logic           w_vld   [LEVELS+1];
    t_item          w_stage [LEVELS+1];
    logic           r_in_vld;
    t_item          r_in;
    t_item          n_in;

    // entry count register, saturated to the table depth
    always_comb begin
        n_count = r_count;
        if (i_cfg_valid) begin
            if ((CW+1)'(i_cfg_data) > DEPTH_C) begin
                n_count = CW'(TABLE_DEPTH);
            end else begin
                n_count = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_cfg_ready = 1'b1;

    // whole pipeline moves unless a result waits at the output
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // entry stage: open the span over the entries in use
    always_comb begin
        n_in.op     = t_op'(i_op);
        n_in.idx    = i_entry_index;
        n_in.value  = i_value;
        n_in.lo     = '0;
        n_in.hi_end = (t_op'(i_op) == OP_SEARCH) ? r_count : '0;
        n_in.mid    = '0;
        n_in.found  = 1'b0;
        n_in.match  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= n_in;
        end
    end

    assign w_vld[0]   = r_in_vld;
    assign w_stage[0] = r_in;

    // one probe level per loop step: table copy, read stage, compare stage
    for (genvar k = 0; k < LEVELS; k++) begin : g_level
        logic [CW:0]               w_sum;
        logic [IW-1:0]             w_mid;
        logic                      w_we;
        logic [VALUE_W-1:0]        w_rdata;
        logic signed [VALUE_W-1:0] w_probe;
        logic                      w_active;
        logic                      r_b_vld;
        t_item                     r_b;
        t_item                     n_b;
        logic                      r_a_vld;
        t_item                     r_a;
        t_item                     n_a;

        // midpoint of the live span, rounding down
        assign w_sum = {1'b0, w_stage[k].lo} + {1'b0, w_stage[k].hi_end} - (CW+1)'(1);
        assign w_mid = w_sum[IW:1];

        // table writes update this copy as they pass
        assign w_we = w_adv && w_vld[k] && (w_stage[k].op == OP_WRITE)
                      && ((CW+1)'(w_stage[k].idx) < DEPTH_C);

        stbs_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_stage[k].idx),
            .i_wdata (w_stage[k].value),
            .i_re    (w_adv),
            .i_raddr (w_mid),
            .o_rdata (w_rdata)
        );

        // read stage: hold the word while the probe is fetched
        always_comb begin
            n_b     = w_stage[k];
            n_b.mid = w_mid;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_vld <= 1'b0;
            end else if (w_adv) begin
                r_b_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_b <= n_b;
            end
        end

        // compare stage: keep the left or right part, or stop on a match
        assign w_probe  = w_rdata;
        assign w_active = !r_b.found && (r_b.lo < r_b.hi_end);

        always_comb begin
            n_a = r_b;
            if (w_active) begin
                if (w_probe == r_b.value) begin
                    n_a.found = 1'b1;
                    n_a.match = r_b.mid;
                end else if (w_probe > r_b.value) begin
                    n_a.hi_end = CW'(r_b.mid);
                end else begin
                    n_a.lo = CW'(r_b.mid) + CW'(1);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld <= 1'b0;
            end else if (w_adv) begin
                r_a_vld <= r_b_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_a <= n_a;
            end
        end

        assign w_vld[k+1]   = r_a_vld;
        assign w_stage[k+1] = r_a;
    end

    // last stage is the output register; write words leave without a result
    assign o_out_valid   = w_vld[LEVELS] && (w_stage[LEVELS].op == OP_SEARCH);
    assign o_found       = w_stage[LEVELS].found;
    assign o_match_index = w_stage[LEVELS].match;

endmodule
`default_nettype wire

@@ tb/sv/sorted_table_binary_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Self-checking bench for the sorted table binary search block. Loads the
// table, steps the entry count through small, random and saturated values,
// and checks every search answer against a halving search run on a private
// copy of the table. Sender bursts and receiver stalls vary the flow.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int IW             = $clog2(TABLE_DEPTH);
    localparam int CW             = $clog2(TABLE_DEPTH + 1);
    localparam int LATENCY        = 2 * CW + 1;
    localparam int QUIET_CYCLES   = 3 * LATENCY;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int PHASE_WORDS    = 90;
    localparam int NUM_PHASES     = 9;

    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] match_index;
    } t_search_result;

    // private copy of the table and the count, plus the answers still owed
    class search_scoreboard;
        logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
        logic [CW-1:0]             entry_count;
        t_search_result            awaiting [$];
        int                        errors;
        int                        checked_count;

        function new();
            entry_count   = '0;
            errors        = 0;
            checked_count = 0;
        endfunction

        function void set_count(logic [CW-1:0] n);
            entry_count = n;
        endfunction

        // halving search over the entries in use, count saturated at the depth
        function t_search_result predict_search(logic signed [VALUE_W-1:0] key);
            int             lo;
            int             hi;
            int             mid;
            t_search_result r;
            r.found       = 1'b0;
            r.match_index = '0;
            lo = 0;
            hi = ((entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count)) - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (table_copy[mid] == key) begin
                    r.found       = 1'b1;
                    r.match_index = mid[IW-1:0];
                    break;
                end else if (table_copy[mid] > key) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            return r;
        endfunction

        function void take_word(t_op op, logic [IW-1:0] idx, logic signed [VALUE_W-1:0] val);
            if (op == OP_WRITE) begin
                table_copy[idx] = val;
            end else begin
                awaiting.push_back(predict_search(val));
            end
        endfunction

        function void check_answer(logic found, logic [IW-1:0] idx);
            t_search_result want;
            checked_count++;
            if (awaiting.size() == 0) begin
                $display("%0t: unexpected result, expected none actual found=%0b index=%0d",
                         $time, found, idx);
                errors++;
                return;
            end
            want = awaiting.pop_front();
            if (found !== want.found) begin
                $display("%0t: found mismatch, expected %0b actual %0b",
                         $time, want.found, found);
                errors++;
            end
            if (idx !== want.match_index) begin
                $display("%0t: match_index mismatch, expected %0d actual %0d",
                         $time, want.match_index, idx);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (awaiting.size() != 0) begin
                $display("%0t: %0d results never arrived, expected next found=%0b index=%0d",
                         $time, awaiting.size(), awaiting[0].found, awaiting[0].match_index);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CW-1:0]             i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_op;
    logic [IW-1:0]             i_entry_index;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic                      o_found;
    logic [IW-1:0]             o_match_index;

    search_scoreboard          sb;
    logic signed [VALUE_W-1:0] shadow [TABLE_DEPTH];
    int                        burst_left = 0;
    int                        idle_cycles = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_entry_index(i_entry_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_match_index(o_match_index)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: every handshake at this edge, input side first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_count(i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.take_word(t_op'(i_op), i_entry_index, i_value);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_answer(o_found, o_match_index);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: stall pattern in modes, two long hold-offs to back up the pipe
    initial begin : receiver
        int mode;
        int mode_left;
        int holdoffs;
        mode      = 0;
        mode_left = 0;
        holdoffs  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoffs < 2 && sb.checked_count >= ((holdoffs == 0) ? 150 : 500)) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoffs++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(1, 80);
            end
            mode_left--;
            case (mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // one input word, sent in bursts with random gaps between them
    task automatic send_word(t_op op, logic [IW-1:0] idx, logic signed [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_value       <= val;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_WRITE) begin
            shadow[idx] = val;
        end
    endtask

    task automatic search_key(logic signed [VALUE_W-1:0] key);
        send_word(OP_SEARCH, IW'($urandom_range(0, TABLE_DEPTH - 1)), key);
    endtask

    // stop sending, wait for every owed answer, then let writes drain
    task automatic drain_and_wait();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaiting.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic set_entry_count(logic [CW-1:0] n);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic signed [VALUE_W-1:0] first_row [8];
        logic [CW-1:0]             phase_counts [NUM_PHASES];
        longint                    acc;
        longint                    lo;
        longint                    hi;
        int                        eff;
        int                        j;
        logic signed [VALUE_W-1:0] val;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_WRITE;
        i_entry_index <= '0;
        i_value       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty span: nothing can match
        set_entry_count('0);
        search_key(32'sd0);
        search_key(VMIN);
        search_key(VMAX);

        // small sorted table spanning both value extremes, plus the top index
        first_row = '{VMIN, -32'sd5, -32'sd1, 32'sd0, 32'sd1, 32'sd100, VMAX - 1, VMAX};
        for (int i = 0; i < 8; i++) begin
            send_word(OP_WRITE, IW'(i), first_row[i]);
        end
        send_word(OP_WRITE, IW'(TABLE_DEPTH - 1), 32'sh5555_AAAA);
        drain_and_wait();
        set_entry_count(CW'(8));
        search_key(VMIN);
        search_key(VMAX);
        search_key(-32'sd1);
        search_key(32'sd0);
        search_key(32'sd100);
        search_key(-32'sd5);
        search_key(32'sd2);
        search_key(-32'sd3);
        search_key(VMAX - 2);

        // single entry span
        drain_and_wait();
        set_entry_count(CW'(1));
        search_key(VMIN);
        search_key(32'sd5);

        // load the whole table ascending, ties allowed, ends pinned to the extremes
        acc = VMIN;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == TABLE_DEPTH - 1) begin
                acc = VMAX;
            end else if (i > 0) begin
                acc += $urandom_range(0, 8_000_000);
            end
            if (acc > VMAX) begin
                acc = VMAX;
            end
            send_word(OP_WRITE, IW'(i), VALUE_W'(acc));
        end

        // random phases over a range of counts, saturated ones included
        phase_counts = '{CW'(1024), CW'(2047), CW'(1), CW'(2), CW'(3), CW'(1025),
                         CW'($urandom_range(4, 1023)), CW'($urandom_range(1026, 2046)),
                         CW'(0)};
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_wait();
            set_entry_count(phase_counts[p]);
            eff = (phase_counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : int'(phase_counts[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    // table update, mostly keeping the order, sometimes breaking it
                    j = (eff > 0 && $urandom_range(0, 4) != 0) ?
                        $urandom_range(0, eff - 1) : $urandom_range(0, TABLE_DEPTH - 1);
                    lo = (j == 0) ? longint'(VMIN) : longint'(shadow[j - 1]);
                    hi = (j == TABLE_DEPTH - 1) ? longint'(VMAX) : longint'(shadow[j + 1]);
                    if ($urandom_range(0, 3) != 0 && lo <= hi) begin
                        val = VALUE_W'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
                    end else begin
                        val = $urandom;
                    end
                    send_word(OP_WRITE, IW'(j), val);
                end else if (eff == 0) begin
                    search_key($urandom);
                end else begin
                    // keys that hit, keys next to an entry, and arbitrary keys
                    j = $urandom_range(0, eff - 1);
                    case ($urandom_range(0, 3))
                        0, 1: begin
                            val = shadow[j];
                        end
                        2: begin
                            val = shadow[j] + (($urandom_range(0, 1) == 1) ? 1 : -1);
                        end
                        default: begin
                            val = $urandom;
                        end
                    endcase
                    search_key(val);
                end
            end
        end

        drain_and_wait();
        sb.report_leftover();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sorted_table_binary_search.f @@
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_tb.sv
